FILE: rtl/core/mbrw_pkg.sv
package mbrw_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MB_W     = 6;
    localparam int IDX_W    = 9;
    localparam int COORD_W  = 10;
    localparam int ADDR_W   = 19;
    localparam int PIXEL_W  = 8;
    localparam int REG_IDX_W = 2;

    localparam logic [IDX_W-1:0]     LAST_IDX        = 9'd383;
    localparam logic [PIXEL_W-1:0]   PIXEL_MAX       = 8'd255;
    localparam logic [MB_W-1:0]      WIDTH_RESET     = 6'd44;
    localparam logic [MB_W-1:0]      HEIGHT_RESET    = 6'd36;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_CB   = 2'd1,
        PLANE_CR   = 2'd2
    } plane_t;

    typedef struct packed {
        plane_t               plane;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   pitch;
        logic                 frame_last;
    } pos_t;

endpackage

FILE: rtl/core/mbrw_position.sv
module mbrw_position #(
    parameter int MAX_WIDTH_MBS  = 44,
    parameter int MAX_HEIGHT_MBS = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          cfg_write,
    input  logic [mbrw_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mbrw_pkg::MB_W-1:0]     cfg_data,
    output mbrw_pkg::pos_t                pos
);
    import mbrw_pkg::*;

    logic [MB_W-1:0]  width_reg;
    logic [MB_W-1:0]  height_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [MB_W-1:0]  mb_col_reg;
    logic [MB_W-1:0]  mb_col_next;
    logic [MB_W-1:0]  mb_row_reg;
    logic [MB_W-1:0]  mb_row_next;
    logic [MB_W-1:0]  w_eff;
    logic [MB_W-1:0]  h_eff;
    logic             last_sample;
    logic             col_wrap;
    logic             row_wrap;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = MB_W'(1);
        else if (32'(width_reg) > MAX_WIDTH_MBS)
            w_eff = MB_W'(MAX_WIDTH_MBS);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = MB_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT_MBS)
            h_eff = MB_W'(MAX_HEIGHT_MBS);
        else
            h_eff = height_reg;
    end

    assign last_sample = (idx_reg == LAST_IDX);
    assign col_wrap    = ({1'b0, mb_col_reg} + 7'd1) >= {1'b0, w_eff};
    assign row_wrap    = ({1'b0, mb_row_reg} + 7'd1) >= {1'b0, h_eff};

    always_comb
    begin
        idx_next    = idx_reg;
        mb_col_next = mb_col_reg;
        mb_row_next = mb_row_reg;
        if (take)
        begin
            if (last_sample)
            begin
                idx_next = '0;
                if (col_wrap)
                begin
                    mb_col_next = '0;
                    mb_row_next = row_wrap ? '0 : mb_row_reg + MB_W'(1);
                end
                else
                begin
                    mb_col_next = mb_col_reg + MB_W'(1);
                end
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        pos.frame_last = last_sample && col_wrap && row_wrap;
        if (!idx_reg[8])
        begin
            pos.plane = PLANE_LUMA;
            pos.row   = {mb_row_reg, idx_reg[7], idx_reg[5:3]};
            pos.col   = {mb_col_reg, idx_reg[6], idx_reg[2:0]};
            pos.pitch = {w_eff, 4'b0000};
        end
        else
        begin
            pos.plane = idx_reg[6] ? PLANE_CR : PLANE_CB;
            pos.row   = {1'b0, mb_row_reg, idx_reg[5:3]};
            pos.col   = {1'b0, mb_col_reg, idx_reg[2:0]};
            pos.pitch = {1'b0, w_eff, 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            idx_reg    <= '0;
            mb_col_reg <= '0;
            mb_row_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_FRAME_WIDTH)
                width_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_FRAME_HEIGHT)
                height_reg <= cfg_data;
            idx_reg    <= idx_next;
            mb_col_reg <= mb_col_next;
            mb_row_reg <= mb_row_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("sample index beyond macroblock");

    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_sample |=> idx_reg == '0)
        else $error("sample index failed to wrap");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && pos.frame_last |=> mb_col_reg == '0 && mb_row_reg == '0)
        else $error("macroblock position failed to wrap at frame end");

endmodule

FILE: rtl/core/mbrw_output.sv
module mbrw_output (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic signed [mbrw_pkg::SAMPLE_W-1:0] sample,
    input  mbrw_pkg::pos_t                 pos,
    input  logic                           write_stall,
    output logic                           sample_stall,
    output logic                           take,
    output logic                           write_valid,
    output logic [1:0]                     plane,
    output logic [mbrw_pkg::ADDR_W-1:0]    address,
    output logic [mbrw_pkg::PIXEL_W-1:0]   pixel,
    output logic                           frame_end
);
    import mbrw_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    plane_t               plane_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [PIXEL_W-1:0]   pixel_reg;
    logic [PIXEL_W-1:0]   pixel_next;
    logic                 end_reg;
    logic [2*COORD_W:0]   addr_full;

    assign sample_stall = valid_reg && write_stall;
    assign take         = sample_valid && !sample_stall;

    assign addr_full = (2*COORD_W+1)'(pos.row) * (2*COORD_W+1)'(pos.pitch)
                     + (2*COORD_W+1)'(pos.col);
    assign addr_next = addr_full[ADDR_W-1:0];

    always_comb
    begin
        if (sample[SAMPLE_W-1])
            pixel_next = '0;
        else if (|sample[SAMPLE_W-2:PIXEL_W])
            pixel_next = PIXEL_MAX;
        else
            pixel_next = sample[PIXEL_W-1:0];
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else
            valid_next = valid_reg && write_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the word while stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            plane_reg <= pos.plane;
            addr_reg  <= addr_next;
            pixel_reg <= pixel_next;
            end_reg   <= pos.frame_last;
        end
    end

    assign write_valid = valid_reg;
    assign plane       = plane_reg;
    assign address     = addr_reg;
    assign pixel       = pixel_reg;
    assign frame_end   = end_reg;

    a_plane_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> plane_reg != 2'd3)
        else $error("invalid plane code on output");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && write_stall |-> !take)
        else $error("word taken while output stalled");

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("accepted word not presented");

endmodule

FILE: rtl/core/macroblock_to_raster_writer.sv
// Channel   Direction  Handshake                    Word
// sample    in         sample_valid / sample_stall  sample
// write     out        write_valid / write_stall    plane, address, pixel, frame_end
// config    in         cfg_write                    cfg_index, cfg_data
//
// One sample per cycle unless stalled; each write appears in the cycle after its
// sample is taken, from the single result register behind the multiply-add.
// Reset: position returns to sample 0 of macroblock (0,0); size registers to 44 x 36.
// sample_stall follows write_stall while a write waits, so the input advances
// whenever the result register is empty or being drained.
module macroblock_to_raster_writer #(
    parameter int MAX_WIDTH_MBS  = 44,
    parameter int MAX_HEIGHT_MBS = 36
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mbrw_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [mbrw_pkg::MB_W-1:0]            cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [mbrw_pkg::SAMPLE_W-1:0] sample,
    output logic                                 write_valid,
    input  logic                                 write_stall,
    output logic [1:0]                           plane,
    output logic [mbrw_pkg::ADDR_W-1:0]          address,
    output logic [mbrw_pkg::PIXEL_W-1:0]         pixel,
    output logic                                 frame_end
);
    import mbrw_pkg::*;

    logic take;
    pos_t pos;

    mbrw_position #(
        .MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
        .MAX_HEIGHT_MBS (MAX_HEIGHT_MBS)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos       (pos)
    );

    mbrw_output u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample       (sample),
        .pos          (pos),
        .write_stall  (write_stall),
        .sample_stall (sample_stall),
        .take         (take),
        .write_valid  (write_valid),
        .plane        (plane),
        .address      (address),
        .pixel        (pixel),
        .frame_end    (frame_end)
    );

endmodule

FILE: bench/tb_macroblock_to_raster_writer.sv
module tb_macroblock_to_raster_writer;
    import mbrw_pkg::*;

    localparam int MAX_W_MBS   = 44;
    localparam int MAX_H_MBS   = 36;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        plane_t               plane;
        logic [ADDR_W-1:0]    address;
        logic [PIXEL_W-1:0]   pixel;
        logic                 frame_end;
    } write_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        bit                         typed;
        write_t                     want;
    } stim_row_t;

    typedef struct packed {
        logic [MB_W-1:0] width;
        logic [MB_W-1:0] height;
        int              count;
    } frame_phase_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       cfg_index;
    logic [MB_W-1:0]            cfg_data;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       write_valid;
    logic                       write_stall;
    logic [1:0]                 plane;
    logic [ADDR_W-1:0]          address;
    logic [PIXEL_W-1:0]         pixel;
    logic                       frame_end;

    bit     word_typed;
    write_t word_want;
    write_t pending_writes[$];
    int     fail_count;
    int     cycles;
    int     burst_left;
    int     stall_mode;
    int     stall_span;

    logic [MB_W-1:0]  width_reg  = WIDTH_RESET;
    logic [MB_W-1:0]  height_reg = HEIGHT_RESET;
    logic [IDX_W-1:0] cur_index  = '0;
    logic [MB_W-1:0]  cur_col    = '0;
    logic [MB_W-1:0]  cur_row    = '0;

    stim_row_t    directed_rows[25];
    frame_phase_t frame_phases[5];

    macroblock_to_raster_writer #(
        .MAX_WIDTH_MBS  (MAX_W_MBS),
        .MAX_HEIGHT_MBS (MAX_H_MBS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .write_valid  (write_valid),
        .write_stall  (write_stall),
        .plane        (plane),
        .address      (address),
        .pixel        (pixel),
        .frame_end    (frame_end)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int eff_size(logic [MB_W-1:0] v, int maxv);
        if (v == 0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic write_t raster_write_for(logic signed [SAMPLE_W-1:0] s);
        write_t w;
        int     fw;
        int     fh;
        int     row;
        int     col;
        int     pitch;
        fw = eff_size(width_reg, MAX_W_MBS);
        fh = eff_size(height_reg, MAX_H_MBS);
        if (cur_index < 256)
        begin
            w.plane = PLANE_LUMA;
            pitch   = fw * 16;
            row     = int'(cur_row) * 16 + 8 * int'(cur_index[7]) + int'(cur_index[5:3]);
            col     = int'(cur_col) * 16 + 8 * int'(cur_index[6]) + int'(cur_index[2:0]);
        end
        else
        begin
            w.plane = (cur_index < 320) ? PLANE_CB : PLANE_CR;
            pitch   = fw * 8;
            row     = int'(cur_row) * 8 + int'(cur_index[5:3]);
            col     = int'(cur_col) * 8 + int'(cur_index[2:0]);
        end
        w.address = ADDR_W'(row * pitch + col);
        if (s < 0)
        begin
            w.pixel = '0;
        end
        else if (s > 255)
        begin
            w.pixel = PIXEL_MAX;
        end
        else
        begin
            w.pixel = s[PIXEL_W-1:0];
        end
        w.frame_end = 1'b0;
        if (cur_index == LAST_IDX)
        begin
            cur_index = '0;
            if (int'(cur_col) + 1 >= fw)
            begin
                cur_col = '0;
                if (int'(cur_row) + 1 >= fh)
                begin
                    cur_row     = '0;
                    w.frame_end = 1'b1;
                end
                else
                begin
                    cur_row = cur_row + 1'b1;
                end
            end
            else
            begin
                cur_col = cur_col + 1'b1;
            end
        end
        else
        begin
            cur_index = cur_index + 1'b1;
        end
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0:       return SAMPLE_W'($urandom);
            1:       return SAMPLE_W'($urandom_range(0, 255));
            2:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 128);
            default: return SAMPLE_W'(-int'($urandom_range(1, 32768)));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        write_t next_write;
        write_t oldest;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == REG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_data;
                end
            end
            if (sample_valid && !sample_stall)
            begin
                next_write = raster_write_for(sample);
                pending_writes.push_back(word_typed ? word_want : next_write);
            end
            if (write_valid && !write_stall)
            begin
                if (pending_writes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word, address %0d", address));
                end
                else
                begin
                    oldest = pending_writes.pop_front();
                    check_field("plane", plane, oldest.plane);
                    check_field("address", address, oldest.address);
                    check_field("pixel", pixel, oldest.pixel);
                    check_field("frame_end", frame_end, oldest.frame_end);
                end
            end
        end
    end

    // receiver: alternate between calm, light, heavy and toggling stretches
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 120);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       write_stall <= 1'b0;
            1:       write_stall <= ($urandom_range(0, 3) == 0);
            2:       write_stall <= ($urandom_range(0, 3) != 0);
            default: write_stall <= ~write_stall;
        endcase
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                               input write_t want);
        int gap;
        sample       <= s;
        word_typed   <= typed;
        word_want    <= want;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // hold the sender until every write is out, then let the pipeline settle
    task automatic drain_writes();
        sample_valid <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_frame_size(input logic [MB_W-1:0] w, input logic [MB_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= REG_SPARE_A;
        cfg_data  <= MB_W'($urandom);
        @(negedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data  <= MB_W'($urandom);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample       = '0;
        write_stall  = 1'b0;
        word_typed   = 1'b0;
        word_want    = '0;
        fail_count   = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_span   = 0;

        directed_rows = '{
            '{16'sh0000, 1'b1, '{PLANE_LUMA, 19'd0,   8'd0,   1'b0}},
            '{16'sh00FF, 1'b1, '{PLANE_LUMA, 19'd1,   8'd255, 1'b0}},
            '{16'sh0100, 1'b1, '{PLANE_LUMA, 19'd2,   8'd255, 1'b0}},
            '{16'shFFFF, 1'b1, '{PLANE_LUMA, 19'd3,   8'd0,   1'b0}},
            '{16'sh8000, 1'b1, '{PLANE_LUMA, 19'd4,   8'd0,   1'b0}},
            '{16'sh7FFF, 1'b1, '{PLANE_LUMA, 19'd5,   8'd255, 1'b0}},
            '{16'sh0001, 1'b1, '{PLANE_LUMA, 19'd6,   8'd1,   1'b0}},
            '{16'sh0080, 1'b1, '{PLANE_LUMA, 19'd7,   8'd128, 1'b0}},
            '{16'sh00FE, 1'b1, '{PLANE_LUMA, 19'd704, 8'd254, 1'b0}},
            '{16'sh5555, 1'b0, '0},
            '{16'shAAAA, 1'b0, '0},
            '{16'sh00AA, 1'b0, '0},
            '{16'sh0055, 1'b0, '0},
            '{16'shFF00, 1'b0, '0},
            '{16'sh7F80, 1'b0, '0},
            '{16'sh0101, 1'b0, '0},
            '{16'shFF01, 1'b0, '0},
            '{16'sh0000, 1'b0, '0},
            '{16'sh00FF, 1'b0, '0},
            '{16'sh8001, 1'b0, '0},
            '{16'sh7FFE, 1'b0, '0},
            '{16'sh0040, 1'b0, '0},
            '{16'sh00C0, 1'b0, '0},
            '{16'shFFFE, 1'b0, '0},
            '{16'sh0010, 1'b0, '0}
        };

        // zero and out-of-range sizes, a shrink that strands the column, then full size
        frame_phases = '{
            '{6'd0,  6'd0,  380},
            '{6'd63, 6'd1,  60},
            '{6'd2,  6'd63, 320},
            '{6'd1,  6'd2,  80},
            '{6'd44, 6'd36, 40}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            push_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_writes();

        foreach (frame_phases[p])
        begin
            set_frame_size(frame_phases[p].width, frame_phases[p].height);
            for (int n = 0; n < frame_phases[p].count; n++)
            begin
                push_sample(random_sample(), 1'b0, '0);
            end
            drain_writes();
        end

        if (pending_writes.size() != 0)
        begin
            report_mismatch($sformatf("%0d words never arrived", pending_writes.size()));
        end
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
